/* rtl/czt_pkg.sv */
package czt_pkg;

    localparam int FOCAL_W  = 16;
    localparam int FACTOR_W = 16;
    localparam int ITERS    = FOCAL_W;
    localparam int CNT_W    = $clog2(ITERS);

    localparam logic [FOCAL_W-1:0] INITIAL_FOCAL = 16'd1306;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ZOOM = 2'd1;
    localparam logic [1:0] PH_COOL = 2'd2;

    localparam logic [3:0] CFG_IN_THR   = 4'd0;
    localparam logic [3:0] CFG_OUT_THR  = 4'd1;
    localparam logic [3:0] CFG_FACTOR   = 4'd2;
    localparam logic [3:0] CFG_ZOOM_MS  = 4'd3;
    localparam logic [3:0] CFG_STABLE   = 4'd4;
    localparam logic [3:0] CFG_COOLDOWN = 4'd5;
    localparam logic [3:0] CFG_LOWER    = 4'd6;
    localparam logic [3:0] CFG_UPPER    = 4'd7;

    typedef struct packed {
        logic                start;
        logic                zoom_in;
        logic [FOCAL_W-1:0]  focal;
        logic [FACTOR_W-1:0] factor;
    } czt_arith_req_t;

    typedef struct packed {
        logic               done;
        logic [FOCAL_W-1:0] value;
    } czt_arith_rsp_t;

endpackage

/* rtl/czt_serial_arith.sv */
module czt_serial_arith
    import czt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  czt_arith_req_t req,
    output czt_arith_rsp_t rsp
);

    typedef enum logic [1:0] {U_IDLE, U_RUN, U_DONE} ust_t;

    localparam int NUM_W = FOCAL_W + 12;

    ust_t                st_reg,   st_next;
    logic                zin_reg,  zin_next;
    logic                sat_reg,  sat_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [FOCAL_W-1:0]  acc_reg,  acc_next;
    logic [FOCAL_W-1:0]  lo_reg,   lo_next;
    logic [FACTOR_W-1:0] opnd_reg, opnd_next;

    logic [FACTOR_W-1:0] div_d;
    logic [NUM_W-1:0]    div_n;
    logic                div_pre_sat;
    logic [FOCAL_W:0]    mul_sum;
    logic [FOCAL_W:0]    div_t;
    logic                div_ge;
    logic [FOCAL_W:0]    div_sub;
    logic [FOCAL_W+4:0]  mul_res;
    logic                mul_sat;

    // divisor of zero is taken as one; numerator carries the half-divisor rounding term
    assign div_d       = (req.factor == '0) ? FACTOR_W'(1) : req.factor;
    assign div_n       = {req.focal, 12'b0} + NUM_W'(div_d[FACTOR_W-1:1]);
    assign div_pre_sat = FACTOR_W'(div_n[NUM_W-1:FOCAL_W]) >= div_d;

    assign mul_sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, opnd_reg} : '0);
    assign div_t   = {acc_reg, lo_reg[FOCAL_W-1]};
    assign div_ge  = div_t >= {1'b0, opnd_reg};
    assign div_sub = div_t - {1'b0, opnd_reg};

    // product >> 12, round half up on bit 11
    assign mul_res = {1'b0, acc_reg, lo_reg[FOCAL_W-1:12]} + (FOCAL_W+5)'(lo_reg[11]);
    assign mul_sat = |mul_res[FOCAL_W+4:FOCAL_W];

    always_comb
    begin
        st_next   = st_reg;
        zin_next  = zin_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        opnd_next = opnd_reg;
        case (st_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    zin_next = req.zoom_in;
                    cnt_next = CNT_W'(ITERS - 1);
                    st_next  = U_RUN;
                    if (req.zoom_in)
                    begin
                        acc_next  = '0;
                        lo_next   = req.factor;
                        opnd_next = req.focal;
                        sat_next  = 1'b0;
                    end
                    else
                    begin
                        acc_next  = FOCAL_W'(div_n[NUM_W-1:FOCAL_W]);
                        lo_next   = div_n[FOCAL_W-1:0];
                        opnd_next = div_d;
                        sat_next  = div_pre_sat;
                    end
                end
            end
            U_RUN:
            begin
                if (zin_reg)
                begin
                    acc_next = mul_sum[FOCAL_W:1];
                    lo_next  = {mul_sum[0], lo_reg[FOCAL_W-1:1]};
                end
                else if (div_ge)
                begin
                    acc_next = div_sub[FOCAL_W-1:0];
                    lo_next  = {lo_reg[FOCAL_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = div_t[FOCAL_W-1:0];
                    lo_next  = {lo_reg[FOCAL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    st_next = U_DONE;
            end
            U_DONE:
            begin
                st_next = U_IDLE;
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            zin_reg  <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            lo_reg   <= '0;
            opnd_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            zin_reg  <= zin_next;
            sat_reg  <= sat_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            lo_reg   <= lo_next;
            opnd_reg <= opnd_next;
        end
    end

    always_comb
    begin
        rsp.done = (st_reg == U_DONE);
        if (zin_reg)
            rsp.value = mul_sat ? '1 : mul_res[FOCAL_W-1:0];
        else
            rsp.value = sat_reg ? '1 : lo_reg;
    end

    // division remainder stays below the divisor unless the quotient already saturated
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == U_RUN && !zin_reg && !sat_reg) |-> ({1'b0, acc_reg} < {1'b0, opnd_reg}))
        else $error("remainder not below divisor");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == U_IDLE && req.start) |=> (st_reg == U_RUN && cnt_reg == CNT_W'(ITERS - 1)))
        else $error("start did not launch iterations");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("done held longer than one cycle");

endmodule

/* rtl/camera_zoom_trigger_fsm_core.sv */
// out_valid rises once an input transfer has passed the evaluate state; when a zoom step
// is computed, the result first waits on the serial unit (16 shift-add or restoring-divide steps).
// One frame at a time: the next input is taken only once the result transfers, and
// out_stall can hold the result; the 16-step serial multiply/divide unit sets the pace.
// Reset (rst_n, async low): idle phase, focal at initial value, counters cleared,
// configuration at its default values.
module camera_zoom_trigger_fsm_core
    import czt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [16:0]        box_ratio,
    input  logic               target_seen,
    input  logic [31:0]        time_ms,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         phase,
    output logic [FOCAL_W-1:0] focal_now,
    output logic               command_valid,
    output logic [FOCAL_W-1:0] command_focal,
    output logic               command_zoom_in,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    typedef enum logic [1:0] {S_WAIT, S_EVAL, S_CALC, S_SEND} st_t;

    localparam logic [FOCAL_W-1:0] MIN_CHANGE    = 16'd3;

    logic [16:0]         in_thr_reg;
    logic [16:0]         out_thr_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [19:0]         zoom_ms_reg;
    logic [15:0]         stable_reg;
    logic [15:0]         cool_len_reg;
    logic [FOCAL_W-1:0]  lower_reg;
    logic [FOCAL_W-1:0]  upper_reg;

    st_t                st_reg,         st_next;
    logic [16:0]        ratio_reg,      ratio_next;
    logic               seen_reg,       seen_next;
    logic [31:0]        now_reg,        now_next;
    logic [1:0]         phase_reg,      phase_next;
    logic [FOCAL_W-1:0] focal_cur_reg,  focal_cur_next;
    logic [FOCAL_W-1:0] focal_pend_reg, focal_pend_next;
    logic [15:0]        run_reg,        run_next;
    logic [15:0]        cool_reg,       cool_next;
    logic [31:0]        began_reg,      began_next;
    logic               want_in_reg,    want_in_next;
    logic               cmd_valid_reg,  cmd_valid_next;
    logic [FOCAL_W-1:0] cmd_focal_reg,  cmd_focal_next;
    logic               cmd_in_reg,     cmd_in_next;

    czt_arith_req_t arith_req;
    czt_arith_rsp_t arith_rsp;

    logic [31:0]        elapsed;
    logic               want_in;
    logic               want_out;
    logic [15:0]        run_inc;
    logic [FOCAL_W-1:0] clamped_focal;
    logic [FOCAL_W-1:0] focal_diff;

    czt_serial_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_thr_reg   <= 17'd655;
            out_thr_reg  <= 17'd16384;
            factor_reg   <= 16'd6144;
            zoom_ms_reg  <= 20'd5500;
            stable_reg   <= 16'd15;
            cool_len_reg <= 16'd30;
            lower_reg    <= 16'd1306;
            upper_reg    <= 16'd12800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IN_THR:   in_thr_reg   <= cfg_data[16:0];
                CFG_OUT_THR:  out_thr_reg  <= cfg_data[16:0];
                CFG_FACTOR:   factor_reg   <= cfg_data[15:0];
                CFG_ZOOM_MS:  zoom_ms_reg  <= cfg_data;
                CFG_STABLE:   stable_reg   <= cfg_data[15:0];
                CFG_COOLDOWN: cool_len_reg <= cfg_data[15:0];
                CFG_LOWER:    lower_reg    <= cfg_data[15:0];
                CFG_UPPER:    upper_reg    <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    assign elapsed  = now_reg - began_reg;
    assign want_in  = ratio_reg < in_thr_reg;
    assign want_out = ratio_reg > out_thr_reg;
    assign run_inc  = (run_reg == 16'hFFFF) ? run_reg : run_reg + 16'd1;

    // clamp only against the limit that matches the direction
    always_comb
    begin
        if (want_in_reg)
            clamped_focal = (arith_rsp.value < upper_reg) ? arith_rsp.value : upper_reg;
        else
            clamped_focal = (arith_rsp.value > lower_reg) ? arith_rsp.value : lower_reg;
        focal_diff = (clamped_focal > focal_cur_reg) ? clamped_focal - focal_cur_reg
                                                     : focal_cur_reg - clamped_focal;
    end

    always_comb
    begin
        st_next         = st_reg;
        ratio_next      = ratio_reg;
        seen_next       = seen_reg;
        now_next        = now_reg;
        phase_next      = phase_reg;
        focal_cur_next  = focal_cur_reg;
        focal_pend_next = focal_pend_reg;
        run_next        = run_reg;
        cool_next       = cool_reg;
        began_next      = began_reg;
        want_in_next    = want_in_reg;
        cmd_valid_next  = cmd_valid_reg;
        cmd_focal_next  = cmd_focal_reg;
        cmd_in_next     = cmd_in_reg;

        arith_req.start   = 1'b0;
        arith_req.zoom_in = want_in;
        arith_req.focal   = focal_cur_reg;
        arith_req.factor  = factor_reg;

        case (st_reg)
            S_WAIT:
            begin
                if (in_valid)
                begin
                    ratio_next = box_ratio;
                    seen_next  = target_seen;
                    now_next   = time_ms;
                    st_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd_valid_next = 1'b0;
                cmd_focal_next = '0;
                cmd_in_next    = 1'b0;
                st_next        = S_SEND;
                case (phase_reg)
                    PH_ZOOM:
                    begin
                        if (elapsed >= {12'b0, zoom_ms_reg})
                        begin
                            focal_cur_next = focal_pend_reg;
                            phase_next     = PH_COOL;
                            cool_next      = cool_len_reg;
                            run_next       = '0;
                        end
                    end
                    PH_COOL:
                    begin
                        if (cool_reg <= 16'd1)
                        begin
                            cool_next  = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                            cool_next = cool_reg - 16'd1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (!seen_reg || (!want_in && !want_out))
                            run_next = '0;
                        else
                        begin
                            run_next = run_inc;
                            if (run_inc >= stable_reg)
                            begin
                                // zoom in wins when both thresholds are met
                                arith_req.start = 1'b1;
                                want_in_next    = want_in;
                                st_next         = S_CALC;
                            end
                        end
                    end
                endcase
            end
            S_CALC:
            begin
                if (arith_rsp.done)
                begin
                    run_next = '0;
                    st_next  = S_SEND;
                    if (focal_diff >= MIN_CHANGE)
                    begin
                        focal_pend_next = clamped_focal;
                        began_next      = now_reg;
                        phase_next      = PH_ZOOM;
                        cmd_valid_next  = 1'b1;
                        cmd_focal_next  = clamped_focal;
                        cmd_in_next     = want_in_reg;
                    end
                end
            end
            S_SEND:
            begin
                if (!out_stall)
                    st_next = S_WAIT;
            end
            default:
            begin
                st_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_WAIT;
            ratio_reg      <= '0;
            seen_reg       <= 1'b0;
            now_reg        <= '0;
            phase_reg      <= PH_IDLE;
            focal_cur_reg  <= INITIAL_FOCAL;
            focal_pend_reg <= INITIAL_FOCAL;
            run_reg        <= '0;
            cool_reg       <= '0;
            began_reg      <= '0;
            want_in_reg    <= 1'b0;
            cmd_valid_reg  <= 1'b0;
            cmd_focal_reg  <= '0;
            cmd_in_reg     <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            ratio_reg      <= ratio_next;
            seen_reg       <= seen_next;
            now_reg        <= now_next;
            phase_reg      <= phase_next;
            focal_cur_reg  <= focal_cur_next;
            focal_pend_reg <= focal_pend_next;
            run_reg        <= run_next;
            cool_reg       <= cool_next;
            began_reg      <= began_next;
            want_in_reg    <= want_in_next;
            cmd_valid_reg  <= cmd_valid_next;
            cmd_focal_reg  <= cmd_focal_next;
            cmd_in_reg     <= cmd_in_next;
        end
    end

    assign in_stall        = (st_reg != S_WAIT);
    assign out_valid       = (st_reg == S_SEND);
    assign phase           = phase_reg;
    assign focal_now       = focal_cur_reg;
    assign command_valid   = cmd_valid_reg;
    assign command_focal   = cmd_focal_reg;
    assign command_zoom_in = cmd_in_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a frame is in flight");

    a_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_valid) |-> (phase == PH_ZOOM))
        else $error("command issued outside zooming");

    a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !command_valid) |-> (command_focal == '0 && !command_zoom_in))
        else $error("command fields not cleared");

    a_run_zoom: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ZOOM) |-> (run_reg == '0))
        else $error("trigger count not cleared while zooming");

    a_calc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CALC && arith_rsp.done) |=> (st_reg == S_SEND))
        else $error("arithmetic result not consumed");

endmodule

/* dv/tb_camera_zoom_trigger_fsm_core.sv */
`timescale 1ns / 1ps

module tb_camera_zoom_trigger_fsm_core;
    import czt_pkg::*;

    typedef struct packed {
        logic [1:0]         phase;
        logic [FOCAL_W-1:0] focal_now;
        logic               cmd_valid;
        logic [FOCAL_W-1:0] cmd_focal;
        logic               cmd_in;
    } frame_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [16:0]        box_ratio = '0;
    logic               target_seen = 1'b0;
    logic [31:0]        time_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         phase;
    logic [FOCAL_W-1:0] focal_now;
    logic               command_valid;
    logic [FOCAL_W-1:0] command_focal;
    logic               command_zoom_in;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [19:0]        cfg_data = '0;

    camera_zoom_trigger_fsm_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .box_ratio       (box_ratio),
        .target_seen     (target_seen),
        .time_ms         (time_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase           (phase),
        .focal_now       (focal_now),
        .command_valid   (command_valid),
        .command_focal   (command_focal),
        .command_zoom_in (command_zoom_in),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    // controller shadow state and register copies
    logic [1:0]         cur_phase;
    logic [FOCAL_W-1:0] focal_cur;
    logic [FOCAL_W-1:0] focal_pend;
    logic [15:0]        trig_run;
    logic [15:0]        cool_left;
    logic [31:0]        zoom_start_ms;
    logic [16:0]        thr_in;
    logic [16:0]        thr_out;
    logic [15:0]        step_factor;
    logic [19:0]        zoom_dur;
    logic [15:0]        need_frames;
    logic [15:0]        cool_frames;
    logic [FOCAL_W-1:0] focal_lo;
    logic [FOCAL_W-1:0] focal_hi;

    frame_result_t pending_results[$];
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic [31:0]   frame_ms = '0;

    task automatic reset_model();
        cur_phase     = PH_IDLE;
        focal_cur     = INITIAL_FOCAL;
        focal_pend    = INITIAL_FOCAL;
        trig_run      = '0;
        cool_left     = '0;
        zoom_start_ms = '0;
        thr_in        = 17'd655;
        thr_out       = 17'd16384;
        step_factor   = 16'd6144;
        zoom_dur      = 20'd5500;
        need_frames   = 16'd15;
        cool_frames   = 16'd30;
        focal_lo      = 16'd1306;
        focal_hi      = 16'd12800;
    endtask

    function automatic logic [FOCAL_W-1:0] scaled_up(input logic [FOCAL_W-1:0] f);
        logic [63:0] p;
        p = (64'(f) * 64'(step_factor) + 64'd2048) >> 12;
        if (p > 64'hFFFF)
            p = 64'hFFFF;
        return (p[15:0] < focal_hi) ? p[15:0] : focal_hi;
    endfunction

    function automatic logic [FOCAL_W-1:0] scaled_down(input logic [FOCAL_W-1:0] f);
        logic [63:0] d;
        logic [63:0] q;
        d = (step_factor == '0) ? 64'd1 : 64'(step_factor);
        q = ((64'(f) << 12) + d / 2) / d;
        if (q > 64'hFFFF)
            q = 64'hFFFF;
        return (q[15:0] > focal_lo) ? q[15:0] : focal_lo;
    endfunction

    function automatic frame_result_t next_frame_result(input logic [16:0] ratio,
                                                        input logic seen,
                                                        input logic [31:0] now);
        frame_result_t      res;
        logic               want_in;
        logic               want_out;
        logic [FOCAL_W-1:0] target;
        logic [FOCAL_W-1:0] delta;
        res = '0;
        if (cur_phase == PH_ZOOM)
        begin
            // modulo 2^32 difference, so a timestamp wrap is harmless
            if (now - zoom_start_ms >= {12'd0, zoom_dur})
            begin
                focal_cur = focal_pend;
                cur_phase = PH_COOL;
                cool_left = cool_frames;
                trig_run  = '0;
            end
        end
        else if (cur_phase == PH_COOL)
        begin
            if (cool_left <= 16'd1)
            begin
                cool_left = '0;
                cur_phase = PH_IDLE;
            end
            else
                cool_left = cool_left - 16'd1;
        end
        else
        begin
            cur_phase = PH_IDLE;
            want_in   = ratio < thr_in;
            want_out  = ratio > thr_out;
            if (!seen || (!want_in && !want_out))
                trig_run = '0;
            else
            begin
                if (trig_run != 16'hFFFF)
                    trig_run = trig_run + 16'd1;
                if (trig_run >= need_frames)
                begin
                    // zoom in wins when both thresholds are met
                    target   = want_in ? scaled_up(focal_cur) : scaled_down(focal_cur);
                    delta    = (target > focal_cur) ? target - focal_cur : focal_cur - target;
                    trig_run = '0;
                    if (delta >= 16'd3)
                    begin
                        focal_pend    = target;
                        zoom_start_ms = now;
                        cur_phase     = PH_ZOOM;
                        res.cmd_valid = 1'b1;
                        res.cmd_focal = target;
                        res.cmd_in    = want_in;
                    end
                end
            end
        end
        res.phase     = cur_phase;
        res.focal_now = focal_cur;
        return res;
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d focal %0d cmd %0b",
                         $time, "actual phase", phase, focal_now, command_valid);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("phase", 16'(want.phase), 16'(phase));
                check_field("focal_now", want.focal_now, focal_now);
                check_field("command_valid", 16'(want.cmd_valid), 16'(command_valid));
                check_field("command_focal", want.cmd_focal, command_focal);
                check_field("command_zoom_in", 16'(want.cmd_in), 16'(command_zoom_in));
            end
        end
    end

    // advances the frame clock by dt ms and transfers one frame
    task automatic send_frame(input logic [16:0] ratio, input logic seen, input int unsigned dt);
        frame_ms = frame_ms + dt;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        box_ratio   <= ratio;
        target_seen <= seen;
        time_ms     <= frame_ms;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(next_frame_result(ratio, seen, frame_ms));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [19:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IN_THR:   thr_in      = value[16:0];
            CFG_OUT_THR:  thr_out     = value[16:0];
            CFG_FACTOR:   step_factor = value[15:0];
            CFG_ZOOM_MS:  zoom_dur    = value;
            CFG_STABLE:   need_frames = value[15:0];
            CFG_COOLDOWN: cool_frames = value[15:0];
            CFG_LOWER:    focal_lo    = value[15:0];
            CFG_UPPER:    focal_hi    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [19:0] zin, input logic [19:0] zout,
                              input logic [19:0] fac, input logic [19:0] dur,
                              input logic [19:0] need, input logic [19:0] cool,
                              input logic [19:0] lo, input logic [19:0] hi);
        write_reg(CFG_IN_THR, zin);
        write_reg(CFG_OUT_THR, zout);
        write_reg(CFG_FACTOR, fac);
        write_reg(CFG_ZOOM_MS, dur);
        write_reg(CFG_STABLE, need);
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_LOWER, lo);
        write_reg(CFG_UPPER, hi);
        cfg_valid <= 1'b0;
    endtask

    // zoom in, hold, zoom out; zero cooldown acts as a single frame
    task automatic test_zoom_cycle();
        settle();
        set_config(655, 16384, 6144, 50, 2, 0, 1306, 12800);
        send_frame(0, 1'b1, 0);
        send_frame(0, 1'b1, 10);
        send_frame(65536, 1'b1, 30);
        send_frame(65536, 1'b1, 20);
        send_frame(65536, 1'b1, 10);
        send_frame(65536, 1'b1, 10);
        send_frame(65536, 1'b0, 10);
        send_frame(65536, 1'b1, 10);
        send_frame(65536, 1'b1, 10);
    endtask

    // both thresholds met at once, zoom started just before the timestamp wraps
    task automatic test_priority_and_wrap();
        settle();
        set_config(40000, 20000, 6144, 50, 1, 1, 1306, 12800);
        frame_ms = 32'hFFFF_FFE0;
        send_frame(30000, 1'b1, 0);
        send_frame(30000, 1'b1, 8);
        send_frame(30000, 1'b1, 8);
        send_frame(30000, 1'b1, 40);
        send_frame(0, 1'b1, 16);
    endtask

    task automatic test_small_change();
        settle();
        set_config(655, 16384, 4100, 0, 1, 1, 0, 65535);
        send_frame(0, 1'b1, 10);
        send_frame(0, 1'b1, 10);
        send_frame(0, 1'b1, 10);
    endtask

    // zero factor, saturation, and limits set the wrong way round
    task automatic test_factor_and_limits();
        settle();
        set_config(655, 16384, 0, 0, 1, 1, 0, 65535);
        send_frame(65536, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(0, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        settle();
        set_config(655, 16384, 65535, 0, 1, 1, 40000, 1000);
        send_frame(0, 1'b1, 10);
        send_frame(65536, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(0, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
        send_frame(5000, 1'b1, 10);
    endtask

    task automatic test_register_extremes();
        settle();
        set_config(0, 65536, 4096, 1048575, 65535, 65535, 65535, 0);
        send_frame(0, 1'b1, 10);
        send_frame(65536, 1'b1, 10);
        send_frame(30000, 1'b0, 10);
        settle();
        set_config(65536, 0, 8192, 1048575, 0, 0, 0, 65535);
        send_frame(100, 1'b1, 10);
        send_frame(100, 1'b1, 1048574);
        send_frame(100, 1'b1, 1);
        send_frame(100, 1'b1, 1);
        send_frame(65536, 1'b1, 1);
        send_frame(100, 1'b1, 10);
    endtask

    function automatic logic [16:0] any_ratio();
        return ($urandom_range(0, 19) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [16:0] trigger_ratio(input logic to_in);
        if (to_in && thr_in != '0)
            return 17'($urandom_range(0, thr_in - 1));
        if (!to_in && thr_out < 17'd65536)
            return 17'($urandom_range(thr_out + 1, 65536));
        return any_ratio();
    endfunction

    task automatic rand_config();
        logic [19:0] zin;
        logic [19:0] zout;
        logic [19:0] fac;
        logic [19:0] dur;
        logic [19:0] lo;
        logic [19:0] hi;
        zin  = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 65536))
                                           : 20'($urandom_range(300, 16000));
        zout = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 65536))
                                           : 20'($urandom_range(12000, 60000));
        case ($urandom_range(0, 9))
            0:       fac = 20'($urandom_range(0, 4095));
            1:       fac = 20'($urandom_range(4096, 65535));
            default: fac = 20'($urandom_range(4096, 12288));
        endcase
        dur = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1048575))
                                          : 20'($urandom_range(0, 300));
        lo  = 20'($urandom_range(0, 4000));
        hi  = 20'($urandom_range(4000, 50000));
        if ($urandom_range(0, 9) == 0)
        begin
            lo = 20'($urandom_range(0, 65535));
            hi = 20'($urandom_range(0, 65535));
        end
        settle();
        set_config(zin, zout, fac, dur, 20'($urandom_range(0, 6)), 20'($urandom_range(0, 8)),
                   lo, hi);
    endtask

    task automatic random_frames(input int count);
        int   sent;
        int   kind;
        int   len;
        int   cut;
        logic to_in;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_until_drained();
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                // run of triggering frames; some are broken by one odd frame
                to_in = 1'($urandom_range(0, 1));
                len   = int'(need_frames) + int'($urandom_range(1, 2));
                cut   = (kind < 64) ? -1 : int'($urandom_range(0, len - 1));
                for (int i = 0; i < len; i++)
                begin
                    if (i != cut)
                        send_frame(trigger_ratio(to_in), 1'b1, $urandom_range(1, 60));
                    else if ($urandom_range(0, 1))
                        send_frame(trigger_ratio(to_in), 1'b0, $urandom_range(1, 60));
                    else
                        send_frame(any_ratio(), 1'b1, $urandom_range(1, 60));
                end
                sent += len;
            end
            else if (kind < 95)
            begin
                send_frame(any_ratio(), 1'($urandom_range(0, 1)), $urandom_range(0, 120));
                sent++;
            end
            else
            begin
                frame_ms = $urandom_range(0, 1) ? $urandom
                                                : 32'hFFFF_FFFF - $urandom_range(0, 300);
                send_frame(any_ratio(), 1'($urandom_range(0, 1)), 0);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int idle_mix[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{12, 12}};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_mix[p][0];
            recv_stall_pct = idle_mix[p][1];
            repeat (2)
            begin
                rand_config();
                random_frames(136);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_zoom_cycle();
        test_priority_and_wrap();
        test_small_change();
        test_factor_and_limits();
        test_register_extremes();
        test_random_traffic();
        hold_until_drained();
        repeat (25) @(posedge clk);
        if (mismatches == 0)
            $display("camera_zoom_trigger_fsm_core test passed");
        else
            $display("camera_zoom_trigger_fsm_core test failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("camera_zoom_trigger_fsm_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/czt_pkg.sv
rtl/czt_serial_arith.sv
rtl/camera_zoom_trigger_fsm_core.sv
dv/tb_camera_zoom_trigger_fsm_core.sv
